/* rtl/projection_intrinsics_defines.svh */
// Assertion macros shared by the projection intrinsics checker.
// Expects signals named clock and reset in the scope of use.
`ifndef PROJECTION_INTRINSICS_DEFINES_SVH
`define PROJECTION_INTRINSICS_DEFINES_SVH

// checked only outside reset
`define PI_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define PI_CHECK_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* rtl/pi_pkg.sv */
// Package for projection_intrinsics: widths, payload types, cell link types
// and the product index tables. No dependencies.
`default_nettype none

package pi_pkg;

   localparam int IN_W       = 48;
   localparam int HALF_W     = 24;
   localparam int PROD_W     = 96;
   localparam int DOT_W      = 98;
   localparam int CROSS_W    = 97;
   localparam int MAG_W      = 96;
   localparam int LIMB_W     = 32;
   localparam int SQ_W       = 192;
   localparam int ROOT_W     = 96;
   localparam int SQRT_REM_W = 97;
   localparam int QUOT_W     = 34;
   localparam int SCALE_SH   = 9;
   localparam int DIV_PRE    = QUOT_W - SCALE_SH;
   localparam int OUT_W      = 32;

   localparam int NUM_WORDS  = 9;
   localparam int NUM_MULS   = 21;
   localparam int NUM_DOTS   = 2;
   localparam int NUM_CROSS  = 6;
   localparam int NUM_ROOTS  = 2;
   localparam int NUM_QUOT   = 4;

   localparam int MUL_LAT    = 3;
   localparam int SQ_LAT     = 3;
   localparam int PAY_DLY    = SQ_LAT + 1 + ROOT_W;
   localparam int LAT        = MUL_LAT + 2 + SQ_LAT + 1 + ROOT_W + 1 + QUOT_W + 1;

   typedef logic [3:0] word_idx_type;

   // product operands, words 0..2 = m1, 3..5 = m2, 6..8 = m3
   // 0..2: m3.m3, 3..5: m1.m3, 6..8: m2.m3, 9..14: m1 x m3 pairs, 15..20: m2 x m3 pairs
   localparam word_idx_type MUL_A [NUM_MULS] = '{
      4'd6, 4'd7, 4'd8, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
      4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1,
      4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4};
   localparam word_idx_type MUL_B [NUM_MULS] = '{
      4'd6, 4'd7, 4'd8, 4'd6, 4'd7, 4'd8, 4'd6, 4'd7, 4'd8,
      4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6,
      4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6};

   typedef struct packed {
      logic signed [IN_W-1:0] proj_r1_c1;
      logic signed [IN_W-1:0] proj_r1_c2;
      logic signed [IN_W-1:0] proj_r1_c3;
      logic signed [IN_W-1:0] proj_r2_c1;
      logic signed [IN_W-1:0] proj_r2_c2;
      logic signed [IN_W-1:0] proj_r2_c3;
      logic signed [IN_W-1:0] proj_r3_c1;
      logic signed [IN_W-1:0] proj_r3_c2;
      logic signed [IN_W-1:0] proj_r3_c3;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] focal_x;
      logic signed [OUT_W-1:0] focal_y;
      logic signed [OUT_W-1:0] center_u;
      logic signed [OUT_W-1:0] center_v;
      logic                    degenerate;
      logic                    overflowed;
   } rsp_type;

   typedef struct packed {
      logic [SQRT_REM_W-1:0] rem;
      logic [ROOT_W-1:0]     root;
      logic [SQ_W-1:0]       rad;
   } sqrt_cell_type;

   typedef struct packed {
      logic [MAG_W-1:0]  rem;
      logic [QUOT_W-1:0] num;
      logic [QUOT_W-1:0] quot;
      logic [MAG_W-1:0]  dsr;
   } div_cell_type;

   typedef struct packed {
      logic [MAG_W-1:0]                s;
      logic [NUM_DOTS-1:0][MAG_W-1:0]  dmag;
      logic [NUM_DOTS-1:0]             dneg;
      logic                            degen;
   } pay_type;

   typedef struct packed {
      logic [NUM_QUOT-1:0] neg;
      logic [NUM_QUOT-1:0] big;
      logic                degen;
   } quot_side_type;

endpackage

`default_nettype wire

/* rtl/pi_mul48.sv */
// Three-stage signed 48x48 multiplier built from four 24-bit partial products.
// Depends on pi_pkg.
`default_nettype none

module pi_mul48 (
   input  logic                          clock,
   input  logic signed [pi_pkg::IN_W-1:0]   op_a,
   input  logic signed [pi_pkg::IN_W-1:0]   op_b,
   output logic signed [pi_pkg::PROD_W-1:0] prod
);
   import pi_pkg::*;

   logic signed [2*HALF_W-1:0]   hh_ff, hh_in;
   logic signed [2*HALF_W:0]     hl_ff, hl_in, lh_ff, lh_in;
   logic        [2*HALF_W-1:0]   ll_ff, ll_in;
   logic signed [PROD_W-1:0]     cat_ff;
   logic signed [2*HALF_W+1:0]   mid_ff, mid_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;

   // a = ah*2^24 + al with ah signed and al unsigned
   always_comb begin
      hh_in  = $signed(op_a[IN_W-1:HALF_W]) * $signed(op_b[IN_W-1:HALF_W]);
      hl_in  = $signed(op_a[IN_W-1:HALF_W]) * $signed({1'b0, op_b[HALF_W-1:0]});
      lh_in  = $signed({1'b0, op_a[HALF_W-1:0]}) * $signed(op_b[IN_W-1:HALF_W]);
      ll_in  = op_a[HALF_W-1:0] * op_b[HALF_W-1:0];
      mid_in = (2*HALF_W+2)'(hl_ff) + (2*HALF_W+2)'(lh_ff);
      prod_in = cat_ff + (PROD_W'(mid_ff) <<< HALF_W);
   end

   always_ff @(posedge clock) begin
      hh_ff   <= hh_in;
      hl_ff   <= hl_in;
      lh_ff   <= lh_in;
      ll_ff   <= ll_in;
      cat_ff  <= {hh_ff, ll_ff};
      mid_ff  <= mid_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* rtl/pi_sq96.sv */
// Three-stage square of a 96-bit unsigned magnitude from six 32x32 products.
// Depends on pi_pkg.
`default_nettype none

module pi_sq96 (
   input  logic                       clock,
   input  logic [pi_pkg::MAG_W-1:0]   val,
   output logic [pi_pkg::SQ_W-1:0]    sq
);
   import pi_pkg::*;

   logic [2*LIMB_W-1:0] p00_ff, p11_ff, p22_ff, p01_ff, p02_ff, p12_ff;
   logic [SQ_W-1:0]     t_ff, t_in, b_ff, sq_ff;

   always_comb begin
      t_in = {p22_ff, p11_ff, p00_ff} + (SQ_W'(p02_ff) << (2*LIMB_W+1));
   end

   always_ff @(posedge clock) begin
      p00_ff <= val[LIMB_W-1:0] * val[LIMB_W-1:0];
      p11_ff <= val[2*LIMB_W-1:LIMB_W] * val[2*LIMB_W-1:LIMB_W];
      p22_ff <= val[3*LIMB_W-1:2*LIMB_W] * val[3*LIMB_W-1:2*LIMB_W];
      p01_ff <= val[LIMB_W-1:0] * val[2*LIMB_W-1:LIMB_W];
      p02_ff <= val[LIMB_W-1:0] * val[3*LIMB_W-1:2*LIMB_W];
      p12_ff <= val[2*LIMB_W-1:LIMB_W] * val[3*LIMB_W-1:2*LIMB_W];
      t_ff   <= t_in;
      // doubled cross terms at bits 33 and 97 do not overlap
      b_ff   <= SQ_W'({p12_ff, p01_ff, {(LIMB_W+1){1'b0}}});
      sq_ff  <= t_ff + b_ff;
   end

   assign sq = sq_ff;

endmodule

`default_nettype wire

/* rtl/pi_sqrt_cell.sv */
// One step of the digit-by-digit integer square root, registered.
// Depends on pi_pkg.
`default_nettype none

module pi_sqrt_cell (
   input  logic                   clock,
   input  pi_pkg::sqrt_cell_type  cell_in,
   output pi_pkg::sqrt_cell_type  cell_out
);
   import pi_pkg::*;

   logic [SQRT_REM_W+1:0] cur, trial, diff;
   logic                  ge;
   sqrt_cell_type         cell_ff, cell_in_nx;

   always_comb begin
      cur   = {cell_in.rem, cell_in.rad[SQ_W-1:SQ_W-2]};
      trial = {1'b0, cell_in.root, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
      cell_in_nx.rem  = ge ? diff[SQRT_REM_W-1:0] : cur[SQRT_REM_W-1:0];
      cell_in_nx.root = {cell_in.root[ROOT_W-2:0], ge};
      cell_in_nx.rad  = {cell_in.rad[SQ_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_nx;
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

/* rtl/pi_div_cell.sv */
// One step of restoring division: one quotient bit per cell, registered.
// Depends on pi_pkg.
`default_nettype none

module pi_div_cell (
   input  logic                  clock,
   input  pi_pkg::div_cell_type  cell_in,
   output pi_pkg::div_cell_type  cell_out
);
   import pi_pkg::*;

   logic [MAG_W:0] cur, diff;
   logic           ge;
   div_cell_type   cell_ff, cell_in_nx;

   always_comb begin
      cur  = {cell_in.rem, cell_in.num[QUOT_W-1]};
      diff = cur - {1'b0, cell_in.dsr};
      ge   = (cur >= {1'b0, cell_in.dsr});
      cell_in_nx.rem  = ge ? diff[MAG_W-1:0] : cur[MAG_W-1:0];
      cell_in_nx.num  = {cell_in.num[QUOT_W-2:0], 1'b0};
      cell_in_nx.quot = {cell_in.quot[QUOT_W-2:0], ge};
      cell_in_nx.dsr  = cell_in.dsr;
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_nx;
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

/* rtl/projection_intrinsics.sv */
// Top level of projection_intrinsics: product pipeline, root and divider cell chains.
// Depends on pi_pkg, pi_mul48, pi_sq96, pi_sqrt_cell, pi_div_cell.
`default_nettype none

// Takes one matrix on every clock where start is high; busy never rises, so an
// item can be issued on every cycle. Each result appears on rsp_data with
// rsp_valid high for exactly one cycle; there is no way to hold it. The pipeline
// runs through three multiplier stages, the sum and magnitude registers, three
// squaring stages, the root input sum, the 96-cell square-root chain, the
// divider prep register, the 34-cell divider chain and the output register.
module projection_intrinsics (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  pi_pkg::req_type req_data,
   output logic            rsp_valid,
   output pi_pkg::rsp_type rsp_data
);
   import pi_pkg::*;

   logic signed [IN_W-1:0]    mw [NUM_WORDS];
   logic signed [PROD_W-1:0]  prod [NUM_MULS];
   logic signed [DOT_W-1:0]   s_full;
   logic [MAG_W-1:0]          s_ff, s_in;
   logic signed [DOT_W-1:0]   d_ff [NUM_DOTS];
   logic signed [DOT_W-1:0]   d_in [NUM_DOTS];
   logic signed [CROSS_W-1:0] cx_ff [NUM_CROSS];
   logic signed [CROSS_W-1:0] cx_in [NUM_CROSS];
   logic [MAG_W-1:0]          ax_ff [NUM_CROSS];
   logic [MAG_W-1:0]          ax_in [NUM_CROSS];
   pay_type                   pay_ff, pay_in;
   logic [SQ_W-1:0]           sqv [NUM_CROSS];
   logic [SQ_W-1:0]           n_ff [NUM_ROOTS];
   sqrt_cell_type             sq_link [NUM_ROOTS][ROOT_W+1];
   pay_type                   dly_ff [PAY_DLY];
   pay_type                   pay_q;
   logic [MAG_W-1:0]          mag [NUM_QUOT];
   div_cell_type              prep_ff [NUM_QUOT];
   div_cell_type              prep_in [NUM_QUOT];
   quot_side_type             side_ff, side_in;
   div_cell_type              div_link [NUM_QUOT][QUOT_W+1];
   quot_side_type             qs_ff [QUOT_W];
   logic [OUT_W:0]            rs [NUM_QUOT];
   rsp_type                   rsp_ff, rsp_in;
   logic [LAT-1:0]            vld_ff, vld_in;

   localparam logic [QUOT_W-1:0] POS_LIM =
      {{(QUOT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] NEG_LIM =
      {{(QUOT_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   // round half up on the doubled quotient, apply sign, saturate; msb = overflow
   function automatic logic [OUT_W:0] round_sat(input logic [QUOT_W-1:0] q,
                                                input logic neg, input logic big);
      logic [QUOT_W:0]   inc;
      logic [QUOT_W-1:0] t;
      logic [QUOT_W-1:0] lim;
      logic [OUT_W:0]    res;
      inc = {1'b0, q} + (QUOT_W+1)'(1);
      t   = inc[QUOT_W:1];
      lim = neg ? NEG_LIM : POS_LIM;
      if (big || (t > lim)) begin
         res = {1'b1, neg ? SAT_NEG : SAT_POS};
      end else begin
         res = {1'b0, neg ? (OUT_W'(0) - t[OUT_W-1:0]) : t[OUT_W-1:0]};
      end
      return res;
   endfunction

   assign busy = 1'b0;

   assign mw[0] = req_data.proj_r1_c1;
   assign mw[1] = req_data.proj_r1_c2;
   assign mw[2] = req_data.proj_r1_c3;
   assign mw[3] = req_data.proj_r2_c1;
   assign mw[4] = req_data.proj_r2_c2;
   assign mw[5] = req_data.proj_r2_c3;
   assign mw[6] = req_data.proj_r3_c1;
   assign mw[7] = req_data.proj_r3_c2;
   assign mw[8] = req_data.proj_r3_c3;

   for (genvar g = 0; g < NUM_MULS; g++) begin : g_mul
      pi_mul48 u_mul (
         .clock (clock),
         .op_a  (mw[MUL_A[g]]),
         .op_b  (mw[MUL_B[g]]),
         .prod  (prod[g])
      );
   end

   // dot products, s and cross components
   always_comb begin
      s_full = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);
      s_in   = s_full[MAG_W-1:0];
      for (int r = 0; r < NUM_DOTS; r++) begin
         d_in[r] = DOT_W'(prod[3+3*r]) + DOT_W'(prod[4+3*r]) + DOT_W'(prod[5+3*r]);
      end
      for (int j = 0; j < NUM_CROSS; j++) begin
         cx_in[j] = CROSS_W'(prod[9+2*j]) - CROSS_W'(prod[10+2*j]);
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_CROSS; j++) begin
         ax_in[j] = cx_ff[j][CROSS_W-1] ? MAG_W'(-cx_ff[j]) : MAG_W'(cx_ff[j]);
      end
      pay_in.s = s_ff;
      for (int r = 0; r < NUM_DOTS; r++) begin
         pay_in.dneg[r] = d_ff[r][DOT_W-1];
         pay_in.dmag[r] = d_ff[r][DOT_W-1] ? MAG_W'(-d_ff[r]) : MAG_W'(d_ff[r]);
      end
      pay_in.degen = (s_ff == '0);
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      d_ff   <= d_in;
      cx_ff  <= cx_in;
      ax_ff  <= ax_in;
      pay_ff <= pay_in;
   end

   for (genvar j = 0; j < NUM_CROSS; j++) begin : g_sq
      pi_sq96 u_sq (
         .clock (clock),
         .val   (ax_ff[j]),
         .sq    (sqv[j])
      );
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NUM_ROOTS; r++) begin
         n_ff[r] <= sqv[3*r] + sqv[3*r+1] + sqv[3*r+2];
      end
   end

   for (genvar r = 0; r < NUM_ROOTS; r++) begin : g_root
      assign sq_link[r][0] = '{rem: '0, root: '0, rad: n_ff[r]};
      for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
         pi_sqrt_cell u_cell (
            .clock    (clock),
            .cell_in  (sq_link[r][k]),
            .cell_out (sq_link[r][k+1])
         );
      end
   end

   // s and dot magnitudes ride alongside the root chains
   always_ff @(posedge clock) begin
      dly_ff[0] <= pay_ff;
      for (int i = 1; i < PAY_DLY; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign pay_q = dly_ff[PAY_DLY-1];

   // numerator is mag*512; quotient needs QUOT_W bits unless it is already too big
   always_comb begin
      mag[0] = sq_link[0][ROOT_W].root;
      mag[1] = sq_link[1][ROOT_W].root;
      mag[2] = pay_q.dmag[0];
      mag[3] = pay_q.dmag[1];
      for (int k = 0; k < NUM_QUOT; k++) begin
         prep_in[k].rem  = MAG_W'(mag[k][MAG_W-1:DIV_PRE]);
         prep_in[k].num  = {mag[k][DIV_PRE-1:0], {SCALE_SH{1'b0}}};
         prep_in[k].quot = '0;
         prep_in[k].dsr  = pay_q.s;
         side_in.big[k]  = {{DIV_PRE{1'b0}}, mag[k]} >= {pay_q.s, {DIV_PRE{1'b0}}};
      end
      side_in.neg   = {pay_q.dneg, {NUM_ROOTS{1'b0}}};
      side_in.degen = pay_q.degen;
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
      side_ff <= side_in;
      qs_ff[0] <= side_ff;
      for (int i = 1; i < QUOT_W; i++) begin
         qs_ff[i] <= qs_ff[i-1];
      end
   end

   for (genvar q = 0; q < NUM_QUOT; q++) begin : g_quot
      assign div_link[q][0] = prep_ff[q];
      for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
         pi_div_cell u_cell (
            .clock    (clock),
            .cell_in  (div_link[q][k]),
            .cell_out (div_link[q][k+1])
         );
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_QUOT; k++) begin
         rs[k] = round_sat(div_link[k][QUOT_W].quot, qs_ff[QUOT_W-1].neg[k],
                           qs_ff[QUOT_W-1].big[k]);
      end
      if (qs_ff[QUOT_W-1].degen) begin
         rsp_in = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.focal_x    = rs[0][OUT_W-1:0];
         rsp_in.focal_y    = rs[1][OUT_W-1:0];
         rsp_in.center_u   = rs[2][OUT_W-1:0];
         rsp_in.center_v   = rs[3][OUT_W-1:0];
         rsp_in.degenerate = 1'b0;
         rsp_in.overflowed = rs[0][OUT_W] | rs[1][OUT_W] | rs[2][OUT_W] | rs[3][OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/pi_checker.sv */
// Port-level checks for projection_intrinsics, bound to the top level.
// Depends on pi_pkg and projection_intrinsics_defines.svh.
`default_nettype none
`include "projection_intrinsics_defines.svh"

module pi_checker (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input pi_pkg::rsp_type rsp_data
);
   import pi_pkg::*;

   `PI_CHECK_ANY(a_never_busy, busy == 1'b0, "busy raised")

   // every result traces back to an item taken a fixed latency earlier
   `PI_CHECK(a_rsp_has_req, rsp_valid |-> $past(start && !busy, LAT), "result without item")

   `PI_CHECK(a_degen_zero, rsp_valid && rsp_data.degenerate |-> rsp_data.focal_x == '0 && rsp_data.focal_y == '0 && rsp_data.center_u == '0 && rsp_data.center_v == '0 && !rsp_data.overflowed, "degenerate item not zeroed")

   `PI_CHECK(a_focal_nonneg, rsp_valid |-> !rsp_data.focal_x[OUT_W-1] && !rsp_data.focal_y[OUT_W-1], "negative focal length")

endmodule

bind projection_intrinsics pi_checker u_pi_checker (.*);

`default_nettype wire
